/* hw/rtl/uer_pkg.sv */
// Shared types and constants for the ultrasonic echo ranger.
// No dependencies; every other file in the project refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package uer_pkg;

  // Default width of the internal tick counter.
  localparam int COUNT_WIDTH_DEF = 16;

  // Field widths of the configuration registers and results.
  localparam int TICKS_W = 16;
  localparam int TRIG_W  = 8;
  localparam int DIST_W  = 17;
  localparam int CFG_W   = 16;

  // Stream payload widths, padded up to whole bytes.
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 40;

  // Register reset values.
  localparam logic [TICKS_W-1:0] TIMEOUT_RESET = 16'd9999;
  localparam logic [TRIG_W-1:0]  TRIGGER_RESET = 8'd2;

  // Saturation limit for the reported count.
  localparam logic [TICKS_W-1:0] TICKS_MAX = 16'hFFFF;

  // floor(t * 17 / 10) is computed as (t * 17 * ceil(2^23 / 10)) >> 23.
  // This is exact for every 16-bit t.
  localparam int               DIST_SHIFT = 23;
  localparam int               DIST_MUL_W = 24;
  localparam logic [DIST_MUL_W-1:0] DIST_MULT = 24'd14260637;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_TIMEOUT = 1'b0,
    REG_TRIGGER = 1'b1
  } reg_idx_t;

  // Measurement phases.
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TRIG = 2'd1,
    PH_WAIT = 2'd2,
    PH_HIGH = 2'd3
  } phase_t;

  // One result item, before it is packed into tdata.
  typedef struct packed {
    logic [DIST_W-1:0]  distance;
    logic [TICKS_W-1:0] echo_ticks;
    logic               timed_out;
    logic               done_res;
    logic               trigger_level;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/uer_distance.sv */
// Tick count to distance conversion, floor(ticks * 17 / 10).
// Uses uer_pkg for the field widths and the reciprocal constant.
`timescale 1ns / 1ps
`default_nettype none

module uer_distance (
  input  wire logic [uer_pkg::TICKS_W-1:0] echo_ticks,
  output logic      [uer_pkg::DIST_W-1:0]  distance
);

  localparam int PROD_W = uer_pkg::TICKS_W + uer_pkg::DIST_MUL_W;

  logic [PROD_W-1:0] product;

  // One constant multiplication; the upper bits are the quotient.
  assign product  = PROD_W'(echo_ticks) * PROD_W'(uer_pkg::DIST_MULT);
  assign distance = product[uer_pkg::DIST_SHIFT +: uer_pkg::DIST_W];

endmodule

`default_nettype wire

/* hw/rtl/ultrasonic_echo_ranger.sv */
// Ultrasonic echo ranger: one stream transaction per timer tick in, one result out.
// The result of a tick is registered and presented in the cycle after its transaction.
// Throughput: one tick per cycle while m_tready allows, set by the single output register stage.
// Reset (rst, synchronous): phase idle, counters zero, registers to their defaults.
// Depends on uer_pkg and uer_distance.
`timescale 1ns / 1ps
`default_nettype none

module ultrasonic_echo_ranger #(
  parameter int COUNT_WIDTH = uer_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // Input stream; s_tdata: [0] start_req, [1] echo_level, rest zero.
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [uer_pkg::IN_DATA_W-1:0]  s_tdata,
  // Output stream; m_tdata: [0] trigger_level, [1] done_res, [2] timed_out,
  // [18:3] echo_ticks, [35:19] distance, rest zero.
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic      [uer_pkg::OUT_DATA_W-1:0] m_tdata,
  // Configuration write port.
  input  wire logic                           cfg_we,
  input  wire logic [0:0]                     cfg_addr,
  input  wire logic [uer_pkg::CFG_W-1:0]      cfg_wdata
);

  // Width wide enough to compare the counter plus carry against the timeout.
  localparam int NW = (COUNT_WIDTH + 1 > uer_pkg::TICKS_W + 1) ?
                      COUNT_WIDTH + 1 : uer_pkg::TICKS_W + 1;

  logic [uer_pkg::TICKS_W-1:0] timeout_ticks;
  logic [uer_pkg::TRIG_W-1:0]  trigger_ticks;

  uer_pkg::phase_t             phase, phase_next;
  logic [COUNT_WIDTH-1:0]      tick_count, tick_count_next;
  logic [uer_pkg::TRIG_W-1:0]  trigger_count, trigger_count_next;

  logic                        in_acc;
  logic                        start_req;
  logic                        echo_level;

  logic [COUNT_WIDTH:0]        tick_inc;
  logic [COUNT_WIDTH-1:0]      tick_sat;
  logic [NW-1:0]               tick_sat_ext;
  logic                        timeout_hit;
  logic [uer_pkg::TRIG_W-1:0]  trig_inc;
  logic [uer_pkg::TRIG_W-1:0]  trig_len;

  logic                        res_trigger;
  logic                        res_done;
  logic                        res_timed_out;
  logic [uer_pkg::TICKS_W-1:0] res_ticks;
  logic [uer_pkg::DIST_W-1:0]  res_distance;
  uer_pkg::result_t            result;

  assign start_req  = s_tdata[0];
  assign echo_level = s_tdata[1];

  // A new tick is taken whenever the output register is free or being emptied.
  assign s_tready = !m_tvalid || m_tready;
  assign in_acc   = s_tvalid && s_tready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= uer_pkg::TIMEOUT_RESET;
      trigger_ticks <= uer_pkg::TRIGGER_RESET;
    end else if (cfg_we) begin
      if (cfg_addr == uer_pkg::REG_TIMEOUT) begin
        timeout_ticks <= cfg_wdata;
      end else begin
        trigger_ticks <= cfg_wdata[uer_pkg::TRIG_W-1:0];
      end
    end
  end

  // Counter arithmetic shared by the next-state and output logic.
  assign tick_inc     = {1'b0, tick_count} + {{COUNT_WIDTH{1'b0}}, 1'b1};
  assign tick_sat     = tick_inc[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} :
                                                tick_inc[COUNT_WIDTH-1:0];
  assign tick_sat_ext = NW'(tick_sat);
  assign timeout_hit  = (NW'(tick_inc) > NW'(timeout_ticks)) || tick_inc[COUNT_WIDTH];
  assign trig_inc     = trigger_count + 8'd1;
  // A trigger length of zero behaves as one tick.
  assign trig_len     = (trigger_ticks == 8'd0) ? 8'd1 : trigger_ticks;

  // Next-state logic for the measurement sequencer.
  always_comb begin
    phase_next         = phase;
    tick_count_next    = tick_count;
    trigger_count_next = trigger_count;
    case (phase)
      uer_pkg::PH_IDLE: begin
        if (start_req) begin
          trigger_count_next = 8'd1;
          if (trig_len <= 8'd1) begin
            phase_next      = uer_pkg::PH_WAIT;
            tick_count_next = '0;
          end else begin
            phase_next = uer_pkg::PH_TRIG;
          end
        end
      end
      uer_pkg::PH_TRIG: begin
        trigger_count_next = trig_inc;
        if ((trig_inc >= trig_len) || (trig_inc == 8'd0)) begin
          phase_next      = uer_pkg::PH_WAIT;
          tick_count_next = '0;
        end
      end
      uer_pkg::PH_WAIT: begin
        tick_count_next = tick_sat;
        if (echo_level) begin
          // Echo rise restarts the count.
          tick_count_next = '0;
          phase_next      = uer_pkg::PH_HIGH;
        end else if (timeout_hit) begin
          phase_next = uer_pkg::PH_IDLE;
        end
      end
      uer_pkg::PH_HIGH: begin
        tick_count_next = tick_sat;
        if (!echo_level) begin
          phase_next = uer_pkg::PH_IDLE;
        end
      end
      default: begin
        phase_next = uer_pkg::PH_IDLE;
      end
    endcase
  end

  // Result fields for the tick being taken; all measurement fields are zero
  // unless the measurement completes on this tick.
  always_comb begin
    res_trigger   = 1'b0;
    res_done      = 1'b0;
    res_timed_out = 1'b0;
    res_ticks     = '0;
    case (phase)
      uer_pkg::PH_IDLE: begin
        res_trigger = start_req;
      end
      uer_pkg::PH_TRIG: begin
        res_trigger = 1'b1;
      end
      uer_pkg::PH_WAIT: begin
        if (!echo_level && timeout_hit) begin
          res_done      = 1'b1;
          res_timed_out = 1'b1;
          res_ticks     = timeout_ticks;
        end
      end
      uer_pkg::PH_HIGH: begin
        if (!echo_level) begin
          res_done  = 1'b1;
          res_ticks = (tick_sat_ext > NW'(uer_pkg::TICKS_MAX)) ? uer_pkg::TICKS_MAX :
                                                                tick_sat_ext[15:0];
        end
      end
      default: begin
        res_trigger = 1'b0;
      end
    endcase
  end

  uer_distance u_distance (
    .echo_ticks (res_ticks),
    .distance   (res_distance)
  );

  assign result.trigger_level = res_trigger;
  assign result.done_res      = res_done;
  assign result.timed_out     = res_timed_out;
  assign result.echo_ticks    = res_ticks;
  assign result.distance      = res_distance;

  // Sequencer state, advanced once per accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= uer_pkg::PH_IDLE;
      tick_count    <= '0;
      trigger_count <= '0;
    end else if (in_acc) begin
      phase         <= phase_next;
      tick_count    <= tick_count_next;
      trigger_count <= trigger_count_next;
    end
  end

  // Output register: holds one result until the downstream side takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_acc) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      m_tdata <= uer_pkg::OUT_DATA_W'(result);
    end
  end

endmodule

`default_nettype wire
